// File: sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Expects the including module to provide clk and the active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/sds_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the SCAN disk scheduler: field widths, codes and defaults.
// No dependencies.
package sds_pkg;

  localparam int MAX_REQUESTS_DEF  = 32;
  localparam int CYLINDER_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int REG_W     = 16;
  localparam int VALUE_W   = 17;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] MAX_CYL_RESET = 16'd4999;

  // Opcodes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Kinds of a result item.
  localparam logic [KIND_W-1:0] KIND_SERVED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOUND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYL  = 2'd2;

endpackage

// File: sv/scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// SCAN (elevator) disk scheduler: request store in one synchronous RAM plus sequencer.
// Depends on sds_pkg and assert_macros.svh.

// Load items (opcode 0) insert a clamped cylinder into a RAM that is kept in
// ascending order. A load into an empty store writes entry 0 directly;
// otherwise the insertion walks down from the top entry, one entry per cycle
// through the single read port. A run item (opcode 1) first scans the store
// to find how many requests lie below the head and the lowest and highest
// request, then emits the head, the first sweep, the boundary, the return
// sweep and the total travel. Each served cylinder from the RAM is read,
// then loaded into the output register. Results leave through an output
// register; the input is taken only while the sequencer is idle. A full
// store ignores further loads, and a run empties the store. Register writes
// are accepted in every cycle.

`include "assert_macros.svh"

module scan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS  = sds_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = sds_pkg::CYLINDER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sds_pkg::REG_W-1:0]      cfg_data,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [sds_pkg::REG_W-1:0]      in_cylinder,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sds_pkg::KIND_W-1:0]     out_kind,
  output logic [sds_pkg::VALUE_W-1:0]    out_value,
  output logic                           out_last
);

  import sds_pkg::*;

  localparam int AW    = $clog2(MAX_REQUESTS);
  localparam int CW    = $clog2(MAX_REQUESTS + 1);
  localparam int CB    = CYLINDER_BITS;
  localparam int CMP_W = (CB > REG_W) ? CB : REG_W;
  localparam int TOT_W = CMP_W + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS     = 9'b000000010,
    S_PUT     = 9'b000000100,
    S_SCAN    = 9'b000001000,
    S_HEAD    = 9'b000010000,
    S_LEG_RD  = 9'b000100000,
    S_LEG_OUT = 9'b001000000,
    S_BOUND   = 9'b010000000,
    S_TOTAL   = 9'b100000000
  } state_t;

  // Mask a cylinder to the store width, then clamp it to the top cylinder.
  function automatic logic [CB-1:0] clamp_cyl(input logic [REG_W-1:0] raw,
                                               input logic [REG_W-1:0] limit);
    logic [31:0]      wide;
    logic [CB-1:0]    masked;
    logic [CMP_W-1:0] m_ext;
    logic [CMP_W-1:0] lim_ext;
    wide    = {16'd0, raw};
    masked  = wide[CB-1:0];
    m_ext   = CMP_W'(masked);
    lim_ext = CMP_W'(limit);
    if (m_ext > lim_ext) begin
      clamp_cyl = CB'(lim_ext);
    end else begin
      clamp_cyl = masked;
    end
  endfunction

  // Configuration registers.
  logic [REG_W-1:0] head_r, prev_r, max_cyl_r;

  // Sequencer state.
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] nlow_r, nlow_nxt;
  logic [CB-1:0] ins_val_r, ins_val_nxt;
  logic [CB-1:0] h_r, h_nxt;
  logic [CB-1:0] lo_r, lo_nxt;
  logic [CB-1:0] hi_r, hi_nxt;
  logic          up_r, up_nxt;
  logic          second_r, second_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  // Request store.
  logic [CB-1:0] store_mem [MAX_REQUESTS];
  logic [CB-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CB-1:0] wr_data;

  logic          in_fire;
  logic [CB-1:0] head_clamped;
  logic [CB-1:0] load_val;
  logic [CW-1:0] cnt_m1, ptr_p1, ptr_m1;
  logic          leg_asc;
  logic [TOT_W-1:0] max_t, h_t, lo_t, hi_t, total_t;
  logic [TOT_W-1:0] h_out_t, rd_out_t, bound_t;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  assign head_clamped = clamp_cyl(head_r, max_cyl_r);
  assign load_val     = clamp_cyl(in_cylinder, max_cyl_r);
  assign cnt_m1       = cnt_r - CW'(1);
  assign ptr_p1       = ptr_r + CW'(1);
  assign ptr_m1       = ptr_r - CW'(1);
  assign leg_asc      = up_r ^ second_r;

  assign max_t    = TOT_W'(max_cyl_r);
  assign h_t      = TOT_W'(h_r);
  assign lo_t     = TOT_W'(lo_r);
  assign hi_t     = TOT_W'(hi_r);
  assign h_out_t  = TOT_W'(h_r);
  assign rd_out_t = TOT_W'(rd_data_r);
  assign bound_t  = up_r ? max_t : '0;

  // Total travel; a sweep with nothing on the far side has no return leg.
  always_comb begin
    if (up_r) begin
      if (nlow_r != '0) begin
        total_t = (max_t << 1) - h_t - lo_t;
      end else begin
        total_t = max_t - h_t;
      end
    end else begin
      if (nlow_r < cnt_r) begin
        total_t = h_t + hi_t;
      end else begin
        total_t = h_t;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    nlow_nxt      = nlow_r;
    ins_val_nxt   = ins_val_r;
    h_nxt         = h_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    up_nxt        = up_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = ins_val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_LOAD) begin
            if (cnt_r != CW'(MAX_REQUESTS)) begin
              ins_val_nxt = load_val;
              cnt_nxt     = cnt_r + CW'(1);
              if (cnt_r == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = load_val;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = cnt_m1[AW-1:0];
                ptr_nxt   = cnt_m1;
                state_nxt = S_INS;
              end
            end
          end else begin
            h_nxt    = head_clamped;
            up_nxt   = CMP_W'(prev_r) < CMP_W'(head_clamped);
            nlow_nxt = '0;
            if (cnt_r != '0) begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_HEAD;
            end
          end
        end
      end

      // Shift larger entries up by one while the next lower entry is read.
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr_p1[AW-1:0];
        if (rd_data_r > ins_val_r) begin
          wr_data = rd_data_r;
          if (ptr_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[AW-1:0];
            ptr_nxt = ptr_m1;
          end
        end else begin
          wr_data   = ins_val_r;
          state_nxt = S_IDLE;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = ins_val_r;
        state_nxt = S_IDLE;
      end

      // The store is sorted, so the number of requests below the head is
      // where the head splits the two sweeps.
      S_SCAN: begin
        if (ptr_r == '0) begin
          lo_nxt = rd_data_r;
        end
        if (rd_data_r < h_r) begin
          nlow_nxt = nlow_r + CW'(1);
        end
        if (ptr_r == cnt_m1) begin
          hi_nxt    = rd_data_r;
          state_nxt = S_HEAD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_p1[AW-1:0];
          ptr_nxt = ptr_p1;
        end
      end

      S_HEAD: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SERVED;
          out_value_nxt = h_out_t[VALUE_W-1:0];
          out_last_nxt  = 1'b0;
          second_nxt    = 1'b0;
          ptr_nxt       = nlow_r;
          state_nxt     = S_LEG_RD;
        end
      end

      // Ascending legs run from nlow up to count - 1, descending legs from
      // nlow - 1 down to 0; the pointer sits one above the entry on the way down.
      S_LEG_RD: begin
        if (leg_asc ? (ptr_r == cnt_r) : (ptr_r == '0)) begin
          state_nxt = second_r ? S_TOTAL : S_BOUND;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = leg_asc ? ptr_r[AW-1:0] : ptr_m1[AW-1:0];
          state_nxt = S_LEG_OUT;
        end
      end

      S_LEG_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SERVED;
          out_value_nxt = rd_out_t[VALUE_W-1:0];
          out_last_nxt  = 1'b0;
          ptr_nxt       = leg_asc ? ptr_p1 : ptr_m1;
          state_nxt     = S_LEG_RD;
        end
      end

      S_BOUND: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BOUND;
          out_value_nxt = bound_t[VALUE_W-1:0];
          out_last_nxt  = 1'b0;
          second_nxt    = 1'b1;
          ptr_nxt       = nlow_r;
          state_nxt     = S_LEG_RD;
        end
      end

      S_TOTAL: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TOTAL;
          out_value_nxt = total_t[VALUE_W-1:0];
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      prev_r    <= '0;
      max_cyl_r <= MAX_CYL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAD:    head_r    <= cfg_data;
        REG_PREV:    prev_r    <= cfg_data;
        REG_MAX_CYL: max_cyl_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    nlow_r      <= nlow_nxt;
    ins_val_r   <= ins_val_nxt;
    h_r         <= h_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    up_r        <= up_nxt;
    second_r    <= second_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  `ASSERT_NEVER(a_cnt_bound, cnt_r > CW'(MAX_REQUESTS), "request count above store depth")
  `ASSERT_NEVER(a_no_rw_same_addr, rd_en && wr_en && (rd_addr == wr_addr),
                "RAM read and write collide")
  `ASSERT_CLK(a_total_ends_run, (state_r == S_TOTAL) && !out_valid_r |=>
              (cnt_r == '0) && out_valid_r && out_last_r && (state_r == S_IDLE),
              "run did not close with total")
  `ASSERT_CLK(a_scan_no_overrun, (state_r == S_SCAN) |-> (nlow_r <= cnt_r),
              "scan counted past the store")

endmodule
